[rtl/core/sprite_table_x_order_keeper_defines.svh]
// assertion macros for the sprite table checker
`ifndef SPRITE_TABLE_X_ORDER_KEEPER_DEFINES_SVH
`define SPRITE_TABLE_X_ORDER_KEEPER_DEFINES_SVH

// antecedent in this cycle, consequent in the next one
`define STXO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite table sequencer check failed");

// antecedent and consequent in the same cycle
`define STXO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite table sequencer check failed");

`endif

[rtl/core/stxo_pkg.sv]
// types, constants and codes of the sprite table with x-ordered rank list
`default_nettype none

package stxo_pkg;

	localparam int NUM_SPRITES = 40;
	localparam int IDX_W = $clog2(NUM_SPRITES);
	localparam int TABLE_BYTES = 4 * NUM_SPRITES;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_IDX = IDX_W'(NUM_SPRITES - 1);

	// request opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// byte lanes within one table entry
	localparam logic [1:0] LANE_Y = 2'd0;
	localparam logic [1:0] LANE_X = 2'd1;
	localparam logic [1:0] LANE_TILE = 2'd2;
	localparam logic [1:0] LANE_FLAGS = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_offset;
		logic [7:0] data_byte;
		logic [5:0] rank;
	} req_t;

	typedef struct packed {
		logic [5:0] sprite_index;
		logic [7:0] pos_y;
		logic [7:0] pos_x;
		logic [7:0] tile_number;
		logic [7:0] attributes;
	} rsp_t;

	// sort key: x byte, then entry number
	typedef struct packed {
		logic [7:0] x;
		idx_t idx;
	} key_t;

	typedef logic [3:0][7:0] entry_bytes_t;

	typedef struct packed {
		logic wr_en;
		idx_t wr_row;
		logic [1:0] wr_lane;
		logic [7:0] wr_data;
		idx_t rd_row;
	} attr_port_t;

	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		idx_t wr_data;
		idx_t rd_addr;
	} rank_port_t;

endpackage

`default_nettype wire

[rtl/core/sprite_table_x_order_keeper.sv]
// top level: sprite attribute table with x-ordered rank list and its sequencer
//
// channel   | handshake            | payload | notes
// ----------+----------------------+---------+-------------------------------
// request   | start, busy          | req     | taken when start && !busy
// result    | done                 | rsp     | one cycle strobe, no back-pressure
//
// steps from request to result strobe:
//   plain write, dma byte, ignored or unused opcode: the dispatch step only
//   read at rank: rank memory read, then attribute row read
//   x write: scan of the rank list for the sprite, then a read, a compare
//     and two writes per neighbour swap and a final check in each direction;
//     the one-read-port rank memory and the single key comparator serialise it
//   last dma byte: insertion sort, rank by rank, shifting entries one by one
// reset clears the sequencer and the valid bits of both memories at once, so
// there is no clearing pass; the next request is taken in the cycle of the
// strobe, and the receiver cannot stall the result
`default_nettype none

module sprite_table_x_order_keeper import stxo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// sequencer states
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_RD_ROW   = 5'd2;
	localparam logic [4:0] S_RD_OUT   = 5'd3;
	localparam logic [4:0] S_MV_SCAN  = 5'd4;
	localparam logic [4:0] S_MV_CHK   = 5'd5;
	localparam logic [4:0] S_UP       = 5'd6;
	localparam logic [4:0] S_UP_ROW   = 5'd7;
	localparam logic [4:0] S_UP_CMP   = 5'd8;
	localparam logic [4:0] S_UP_W2    = 5'd9;
	localparam logic [4:0] S_DN       = 5'd10;
	localparam logic [4:0] S_DN_ROW   = 5'd11;
	localparam logic [4:0] S_DN_CMP   = 5'd12;
	localparam logic [4:0] S_DN_W2    = 5'd13;
	localparam logic [4:0] S_SO_I     = 5'd14;
	localparam logic [4:0] S_SO_I_ROW = 5'd15;
	localparam logic [4:0] S_SO_I_X   = 5'd16;
	localparam logic [4:0] S_SO_J     = 5'd17;
	localparam logic [4:0] S_SO_J_ROW = 5'd18;
	localparam logic [4:0] S_SO_J_CMP = 5'd19;
	localparam logic [4:0] S_SO_PLACE = 5'd20;

	logic [4:0] state_q, state_d;
	req_t req_q, req_d;
	idx_t pos_q, pos_d;     // rank of the moving sprite, or outer sort index
	idx_t j_q, j_d;         // insertion point during the sort
	idx_t b_q, b_d;         // neighbour entry just read from the rank list, or the entry at the read rank
	key_t key_q, key_d;     // key of the moving or inserted sprite
	logic done_q, done_d;
	rsp_t rsp_q, rsp_d;

	attr_port_t attr_port;
	rank_port_t rank_port;
	entry_bytes_t attr_rd;
	idx_t rank_rd;

	key_t cmp_a, cmp_b, mem_key;
	logic a_first;

	// request decode
	logic in_table;
	logic rank_ok;
	idx_t wr_row;
	logic [1:0] wr_lane;

	assign in_table = {1'b0, req_q.byte_offset} < 9'(TABLE_BYTES);
	assign rank_ok = {1'b0, req_q.rank} < 7'(NUM_SPRITES);
	assign wr_row = req_q.byte_offset[IDX_W+1:2];
	assign wr_lane = req_q.byte_offset[1:0];

	stxo_attr_mem u_attr (
		.clk     (clk),
		.arst_n  (arst_n),
		.port    (attr_port),
		.rd_data (attr_rd)
	);

	stxo_rank_mem u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.port    (rank_port),
		.rd_data (rank_rd)
	);

	// one comparator for every ordering decision; moving up asks whether the
	// neighbour goes before the sprite, all other steps ask the reverse
	assign mem_key = '{x: attr_rd[LANE_X], idx: b_q};

	always_comb begin
		if (state_q == S_UP_CMP) begin
			cmp_a = mem_key;
			cmp_b = key_q;
		end else begin
			cmp_a = key_q;
			cmp_b = mem_key;
		end
	end

	stxo_key_cmp u_cmp (
		.a       (cmp_a),
		.b       (cmp_b),
		.a_first (a_first)
	);

	always_comb begin
		state_d = state_q;
		req_d = req_q;
		pos_d = pos_q;
		j_d = j_q;
		b_d = b_q;
		key_d = key_q;
		done_d = 1'b0;
		rsp_d = rsp_q;
		attr_port = '0;
		rank_port = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = req;
					rsp_d = '0;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (req_q.opcode) inside
					OP_WRITE, OP_LOAD: begin
						if (in_table) begin
							attr_port.wr_en = 1'b1;
							attr_port.wr_row = wr_row;
							attr_port.wr_lane = wr_lane;
							attr_port.wr_data = req_q.data_byte;
							if (req_q.opcode == OP_WRITE && wr_lane == LANE_X) begin
								key_d = '{x: req_q.data_byte, idx: wr_row};
								pos_d = '0;
								state_d = S_MV_SCAN;
							end else if (req_q.opcode == OP_LOAD &&
									{1'b0, req_q.byte_offset} == 9'(TABLE_BYTES - 1)) begin
								pos_d = idx_t'(1);
								state_d = S_SO_I;
							end else begin
								done_d = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							done_d = 1'b1;
							state_d = S_IDLE;
						end
					end
					OP_READ: begin
						if (rank_ok) begin
							rank_port.rd_addr = req_q.rank[IDX_W-1:0];
							state_d = S_RD_ROW;
						end else begin
							done_d = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						done_d = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			// read at rank
			S_RD_ROW: begin
				attr_port.rd_row = rank_rd;
				b_d = rank_rd;
				state_d = S_RD_OUT;
			end
			S_RD_OUT: begin
				rsp_d.sprite_index = 6'(b_q);
				rsp_d.pos_y = attr_rd[LANE_Y];
				rsp_d.pos_x = attr_rd[LANE_X];
				rsp_d.tile_number = attr_rd[LANE_TILE];
				rsp_d.attributes = attr_rd[LANE_FLAGS];
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			// find the rank that holds the written sprite
			S_MV_SCAN: begin
				rank_port.rd_addr = pos_q;
				state_d = S_MV_CHK;
			end
			S_MV_CHK: begin
				if (rank_rd == key_q.idx) begin
					state_d = S_UP;
				end else if (pos_q == LAST_IDX) begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					pos_d = pos_q + idx_t'(1);
					state_d = S_MV_SCAN;
				end
			end
			// bubble towards higher ranks
			S_UP: begin
				if (pos_q == LAST_IDX) begin
					state_d = S_DN;
				end else begin
					rank_port.rd_addr = pos_q + idx_t'(1);
					state_d = S_UP_ROW;
				end
			end
			S_UP_ROW: begin
				attr_port.rd_row = rank_rd;
				b_d = rank_rd;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (a_first) begin
					rank_port.wr_en = 1'b1;
					rank_port.wr_addr = pos_q;
					rank_port.wr_data = b_q;
					state_d = S_UP_W2;
				end else begin
					state_d = S_DN;
				end
			end
			S_UP_W2: begin
				rank_port.wr_en = 1'b1;
				rank_port.wr_addr = pos_q + idx_t'(1);
				rank_port.wr_data = key_q.idx;
				pos_d = pos_q + idx_t'(1);
				state_d = S_UP;
			end
			// bubble towards lower ranks
			S_DN: begin
				if (pos_q == '0) begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					rank_port.rd_addr = pos_q - idx_t'(1);
					state_d = S_DN_ROW;
				end
			end
			S_DN_ROW: begin
				attr_port.rd_row = rank_rd;
				b_d = rank_rd;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (a_first) begin
					rank_port.wr_en = 1'b1;
					rank_port.wr_addr = pos_q;
					rank_port.wr_data = b_q;
					state_d = S_DN_W2;
				end else begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DN_W2: begin
				rank_port.wr_en = 1'b1;
				rank_port.wr_addr = pos_q - idx_t'(1);
				rank_port.wr_data = key_q.idx;
				pos_d = pos_q - idx_t'(1);
				state_d = S_DN;
			end
			// insertion sort of the whole list after the last dma byte
			S_SO_I: begin
				rank_port.rd_addr = pos_q;
				state_d = S_SO_I_ROW;
			end
			S_SO_I_ROW: begin
				attr_port.rd_row = rank_rd;
				key_d.idx = rank_rd;
				j_d = pos_q;
				state_d = S_SO_I_X;
			end
			S_SO_I_X: begin
				key_d.x = attr_rd[LANE_X];
				state_d = S_SO_J;
			end
			S_SO_J: begin
				if (j_q == '0) begin
					state_d = S_SO_PLACE;
				end else begin
					rank_port.rd_addr = j_q - idx_t'(1);
					state_d = S_SO_J_ROW;
				end
			end
			S_SO_J_ROW: begin
				attr_port.rd_row = rank_rd;
				b_d = rank_rd;
				state_d = S_SO_J_CMP;
			end
			S_SO_J_CMP: begin
				if (a_first) begin
					rank_port.wr_en = 1'b1;
					rank_port.wr_addr = j_q;
					rank_port.wr_data = b_q;
					j_d = j_q - idx_t'(1);
					state_d = S_SO_J;
				end else begin
					state_d = S_SO_PLACE;
				end
			end
			S_SO_PLACE: begin
				rank_port.wr_en = 1'b1;
				rank_port.wr_addr = j_q;
				rank_port.wr_data = key_q.idx;
				if (pos_q == LAST_IDX) begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					pos_d = pos_q + idx_t'(1);
					state_d = S_SO_I;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
		end
	end

	// payload and work registers need no reset
	always_ff @(posedge clk) begin
		req_q <= req_d;
		pos_q <= pos_d;
		j_q <= j_d;
		b_q <= b_d;
		key_q <= key_d;
		rsp_q <= rsp_d;
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

[rtl/core/stxo_key_cmp.sv]
// shared key comparator: x byte first, entry number breaks ties
`default_nettype none

module stxo_key_cmp import stxo_pkg::*; (
	input  key_t a,
	input  key_t b,
	output logic a_first
);

	always_comb begin
		if (a.x != b.x) begin
			a_first = a.x < b.x;
		end else begin
			a_first = a.idx < b.idx;
		end
	end

endmodule

`default_nettype wire

[rtl/core/stxo_attr_mem.sv]
// attribute table: four byte lanes per entry, per-byte valid bits for the zero reset
`default_nettype none

module stxo_attr_mem import stxo_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  attr_port_t   port,
	output entry_bytes_t rd_data
);

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [7:0] mem [NUM_SPRITES];
		logic [NUM_SPRITES-1:0] vld_q;
		logic [7:0] rd_q;
		logic rd_vld_q;
		logic wr_hit;

		assign wr_hit = port.wr_en && (port.wr_lane == 2'(l));

		always_ff @(posedge clk) begin
			if (wr_hit) begin
				mem[port.wr_row] <= port.wr_data;
			end
			rd_q <= mem[port.rd_row];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
				rd_vld_q <= 1'b0;
			end else begin
				if (wr_hit) begin
					vld_q[port.wr_row] <= 1'b1;
				end
				rd_vld_q <= vld_q[port.rd_row];
			end
		end

		// never written bytes read as zero
		assign rd_data[l] = rd_vld_q ? rd_q : 8'd0;
	end

endmodule

`default_nettype wire

[rtl/core/stxo_rank_mem.sv]
// rank list memory, identity after reset through per-entry valid bits
`default_nettype none

module stxo_rank_mem import stxo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rank_port_t port,
	output idx_t       rd_data
);

	idx_t mem [NUM_SPRITES];
	logic [NUM_SPRITES-1:0] vld_q;
	idx_t rd_q;
	idx_t rd_addr_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (port.wr_en) begin
			mem[port.wr_addr] <= port.wr_data;
		end
		rd_q <= mem[port.rd_addr];
		rd_addr_q <= port.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (port.wr_en) begin
				vld_q[port.wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[port.rd_addr];
		end
	end

	// untouched rank i holds entry i
	assign rd_data = rd_vld_q ? rd_q : rd_addr_q;

endmodule

`default_nettype wire

[rtl/core/stxo_checker.sv]
// port-level checks on the sprite table sequencer, bound to the top level
`default_nettype none

`include "sprite_table_x_order_keeper_defines.svh"

module stxo_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// a taken request makes the block busy in the next cycle, with no strobe yet
	`STXO_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)

	// the result strobe comes with the sequencer back at rest
	`STXO_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)

	// one strobe per request, never two in a row
	`STXO_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)

	// no result without a request in flight
	`STXO_ASSERT_NEXT(a_no_spurious, clk, arst_n, !busy && !start, !done)

endmodule

bind sprite_table_x_order_keeper stxo_checker u_stxo_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
